// ===== design/button_debounce_hold_repeat_core_macros.svh =====
// Assertion macros shared by the debouncer RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define BDHR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bdhr assertion failed");
// Checked at every rising edge, reset included.
`define BDHR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bdhr assertion failed");
`else
`define BDHR_ASSERT(lbl, clk, rst, prop)
`define BDHR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/bdhr_pkg.sv =====
package bdhr_pkg;

  localparam int SAMPLE_W = 8;
  localparam int TIME_W   = 16;
  localparam int EVENT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] SAMPLE_PERIOD_RST = 8'd10;
  localparam logic [TIME_W-1:0]   HOLD_TIME_RST     = 16'd1000;
  localparam logic [TIME_W-1:0]   REPEAT_TIME_RST   = 16'd200;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_HOLD    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_HOLD_TIME     = 2'd1,
    CFG_REPEAT_TIME   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_period;
    logic [TIME_W-1:0]   hold_time;
    logic [TIME_W-1:0]   repeat_time;
  } bdhr_cfg_t;

  typedef struct packed {
    ev_code_t code;
    logic     down;
    logic     held;
  } bdhr_result_t;

endpackage

// ===== design/bdhr_cfg.sv =====
module bdhr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bdhr_pkg::bdhr_cfg_t                 cfg
);
  import bdhr_pkg::*;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period <= SAMPLE_PERIOD_RST;
      cfg.hold_time     <= HOLD_TIME_RST;
      cfg.repeat_time   <= REPEAT_TIME_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data[SAMPLE_W-1:0];
        CFG_HOLD_TIME:     cfg.hold_time     <= cfg_data[TIME_W-1:0];
        CFG_REPEAT_TIME:   cfg.repeat_time   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bdhr_update.sv =====
module bdhr_update #(
  parameter int INTEGRATOR_LIMIT = 5,
  parameter int PRESS_THRESHOLD  = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bdhr_pkg::bdhr_cfg_t     cfg,
  input  logic                    fire,
  input  logic                    raw,
  output bdhr_pkg::bdhr_result_t  result
);
  import bdhr_pkg::*;

  localparam int INT_W = $clog2(INTEGRATOR_LIMIT + 1);
  localparam logic [INT_W-1:0]    INT_MAX    = INT_W'(INTEGRATOR_LIMIT);
  localparam logic [SAMPLE_W-1:0] SAMPLE_SAT = '1;
  localparam logic [TIME_W-1:0]   TIME_SAT   = '1;

  logic [SAMPLE_W-1:0] sample_elapsed, sample_elapsed_next, sample_inc;
  logic [INT_W-1:0]    integrator, integrator_next, integ_step;
  logic                down_flag, down_flag_next;
  logic                hold_flag, hold_flag_next;
  logic [TIME_W-1:0]   event_elapsed, event_elapsed_next, event_inc;
  logic                sample;
  logic                now_down;
  ev_code_t            ev;

  // Saturating elapsed counters and the sampling decision.
  always_comb begin
    sample_inc = (sample_elapsed == SAMPLE_SAT) ? sample_elapsed : sample_elapsed + 1'b1;
    event_inc  = (event_elapsed == TIME_SAT) ? event_elapsed : event_elapsed + 1'b1;
    sample     = sample_inc >= cfg.sample_period;
  end

  // Integrator step, bounded at zero and at the limit.
  always_comb begin
    if (raw) begin
      integ_step = (integrator < INT_MAX) ? integrator + 1'b1 : INT_MAX;
    end else begin
      integ_step = (integrator != '0) ? integrator - 1'b1 : integrator;
    end
    now_down = int'(integ_step) >= PRESS_THRESHOLD;
  end

  // Event selection on a sampling tick.
  always_comb begin
    ev = EV_NONE;
    if (sample) begin
      if (down_flag) begin
        if (!now_down) begin
          ev = EV_RELEASE;
        end else if (hold_flag) begin
          if (event_inc >= cfg.repeat_time) ev = EV_REPEAT;
        end else if (event_inc >= cfg.hold_time) begin
          ev = EV_HOLD;
        end
      end else if (now_down) begin
        ev = EV_PRESS;
      end
    end
  end

  // Next state.
  always_comb begin
    sample_elapsed_next = sample ? '0 : sample_inc;
    integrator_next     = sample ? integ_step : integrator;
    down_flag_next      = sample ? now_down : down_flag;
    event_elapsed_next  = (ev != EV_NONE) ? '0 : event_inc;
    hold_flag_next      = hold_flag;
    if (ev == EV_HOLD) hold_flag_next = 1'b1;
    if (sample && !now_down) hold_flag_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_elapsed <= '0;
      integrator     <= '0;
      down_flag      <= 1'b0;
      hold_flag      <= 1'b0;
      event_elapsed  <= '0;
    end else if (fire) begin
      sample_elapsed <= sample_elapsed_next;
      integrator     <= integrator_next;
      down_flag      <= down_flag_next;
      hold_flag      <= hold_flag_next;
      event_elapsed  <= event_elapsed_next;
    end
  end

  assign result.code = ev;
  assign result.down = down_flag_next;
  assign result.held = hold_flag_next;

endmodule

// ===== design/bdhr_out_fifo.sv =====
module bdhr_out_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  bdhr_pkg::bdhr_result_t  push_data,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bdhr_pkg::bdhr_result_t  head
);
  import bdhr_pkg::*;

  bdhr_result_t slots [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         pop;

  // Two-entry result buffer so the update stage keeps running while a beat waits.
  assign pop       = out_valid && !out_stall;
  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/button_debounce_hold_repeat_core.sv =====
// Path: a beat accepted into the input register moves on into the result buffer
// and is offered on out_valid from there; it waits while the result buffer is full.
// Throughput: one tick beat per cycle unless the result buffer is full; the debounce
// update is a single registered pass between the input register and the two-entry result buffer.
// Reset (rst, synchronous, active high) clears the integrator, flags, counters
// and pipeline, and restores the period 10, hold 1000 and repeat 200 ticks.
`include "button_debounce_hold_repeat_core_macros.svh"

module button_debounce_hold_repeat_core #(
  parameter int INTEGRATOR_LIMIT = 5,
  parameter int PRESS_THRESHOLD  = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             raw_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bdhr_pkg::EVENT_W-1:0]     event_code,
  output logic                             is_down,
  output logic                             is_held
);
  import bdhr_pkg::*;

  bdhr_cfg_t    cfg;
  bdhr_result_t result, head;
  logic         in_q_valid, in_q_raw;
  logic         fire, full;

  bdhr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: holds one tick beat until the update stage takes it.
  assign fire     = in_q_valid && !full;
  assign in_stall = in_q_valid && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_q_raw <= raw_level;
  end

  bdhr_update #(
    .INTEGRATOR_LIMIT (INTEGRATOR_LIMIT),
    .PRESS_THRESHOLD  (PRESS_THRESHOLD)
  ) u_update (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .raw    (in_q_raw),
    .result (result)
  );

  bdhr_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_code = head.code;
  assign is_down    = head.down;
  assign is_held    = head.held;

  // Hold is only ever reported while the button is down.
  `BDHR_ASSERT(a_held_implies_down, clk, rst, out_valid |-> (!is_held || is_down))
  // A press beat is down and not yet held.
  `BDHR_ASSERT(a_press_state, clk, rst, (out_valid && event_code == EV_PRESS) |-> (is_down && !is_held))
  // A hold beat sets the held state.
  `BDHR_ASSERT(a_hold_sets_held, clk, rst, (out_valid && event_code == EV_HOLD) |-> is_held)
  // A release beat always shows the button up and hold cleared.
  `BDHR_ASSERT(a_release_state, clk, rst, (out_valid && event_code == EV_RELEASE) |-> (!is_down && !is_held))
  // The input side stalls only on a full result buffer.
  `BDHR_ASSERT_ALWAYS(a_stall_when_full, clk, in_stall |-> full)

endmodule
